FILE: src/srsf_pkg.sv
// srsf_pkg: shared widths, reset values, datapath operation codes and status word
// for the stepper ramp segment fitter; no dependencies
package srsf_pkg;

	// field and register widths
	localparam int TIMER_W  = 27;
	localparam int TOL_W    = 16;
	localparam int FIELD_W  = 24;
	localparam int FI_W     = 27;
	localparam int CNT_W    = 16;
	localparam int SLOPE_W  = 32;

	// configuration reset values and parameter defaults
	localparam logic [TIMER_W-1:0] TIMER_RST = 27'd25000000;
	localparam logic [TOL_W-1:0]   TOL_RST   = 16'd131;
	localparam int ADD_SHIFT_DEF = 16;
	localparam int MAX_RUN_DEF   = 65535;

	// internal arithmetic widths
	localparam int IV_W    = 43;  // interval, q.16 ticks
	localparam int DSR_W   = 48;  // widest divisor
	localparam int QUO_W   = 45;  // kept quotient bits, overflow is sticky
	localparam int SN_W    = 62;  // slope numerator magnitude
	localparam int RAD_W   = 56;  // square root radicand
	localparam int ROOT_W  = 28;  // square root result

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_TIMER = 1'b0,
		REG_TOL   = 1'b1
	} cfg_reg_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQUARE,
		OP_DIFF,
		OP_FRAC_GO,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_V2,
		OP_SQRT_GO,
		OP_IV_GO,
		OP_TAKE_FIRST,
		OP_TAKE_SECOND,
		OP_RUN_ALW,
		OP_RUN_ACC,
		OP_FIN1,
		OP_FIN2,
		OP_SLOPE_GO,
		OP_RES_RUN,
		OP_RES_ONE,
		OP_RES_ZERO
	} dp_op_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic finished;
		logic last_step;
		logic run_more;
		logic dev_fail;
		logic div_busy;
		logic sqrt_busy;
	} dp_status_t;

	// interval tolerance, at least one tick
	function automatic logic [IV_W-1:0] allowance(input logic [IV_W-1:0] iv,
			input logic [TOL_W-1:0] tol);
		logic [IV_W+TOL_W-1:0] p;
		logic [IV_W-1:0] a;
		p = (IV_W+TOL_W)'(iv) * (IV_W+TOL_W)'(tol);
		a = p[IV_W+TOL_W-1:TOL_W];
		allowance = (a < IV_W'(65536)) ? IV_W'(65536) : a;
	endfunction

endpackage

FILE: src/srsf_div.sv
// srsf_div: restoring divider, one quotient bit per cycle
// depends on srsf_pkg
module srsf_div #(
	parameter int DVD_W = 79
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DVD_W-1:0]              dividend,
	input  logic [srsf_pkg::DSR_W-1:0]    divisor,
	input  logic [$clog2(DVD_W+1)-1:0]    nbits,
	output logic                          busy,
	output logic [srsf_pkg::QUO_W-1:0]    quo,
	output logic                          ovf
);
	import srsf_pkg::*;

	localparam int CW = $clog2(DVD_W+1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DSR_W:0]    rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ovf_q;
	logic [DSR_W:0]    trial;
	logic              ge;

	// trial subtract
	assign trial = {rem_q[DSR_W-1:0], dvd_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, dsr_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;
endmodule

FILE: src/srsf_sqrt.sv
// srsf_sqrt: integer square root, one result bit per cycle
// depends on srsf_pkg
module srsf_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [srsf_pkg::RAD_W-1:0]    radicand,
	output logic                          busy,
	output logic [srsf_pkg::ROOT_W-1:0]   root
);
	import srsf_pkg::*;

	localparam int CW = $clog2(ROOT_W+1);

	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [RAD_W-1:0] x_q;
	logic [RAD_W:0]   r_q;
	logic [RAD_W:0]   bit_q;
	logic [RAD_W:0]   s;

	assign s = r_q + bit_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// digit by digit root
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			r_q   <= '0;
			bit_q <= (RAD_W+1)'(1) << (RAD_W-2);
		end else if (busy_q) begin
			if ({1'b0, x_q} >= s) begin
				x_q <= x_q - s[RAD_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[ROOT_W-1:0];
endmodule

FILE: src/srsf_datapath.sv
// srsf_datapath: config registers, interval arithmetic, run accumulators, slope and result words
// depends on srsf_pkg, srsf_div, srsf_sqrt
module srsf_datapath #(
	parameter int ADD_SHIFT = srsf_pkg::ADD_SHIFT_DEF,
	parameter int MAX_RUN   = srsf_pkg::MAX_RUN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srsf_pkg::dp_op_t                  op,
	output srsf_pkg::dp_status_t              status,
	input  logic [srsf_pkg::FIELD_W-1:0]      start_speed,
	input  logic [srsf_pkg::FIELD_W-1:0]      end_speed,
	input  logic [srsf_pkg::FIELD_W-1:0]      step_total,
	input  logic [srsf_pkg::FIELD_W-1:0]      step_index,
	input  logic                              cfg_wr_en,
	input  logic [0:0]                        cfg_index,
	input  logic [srsf_pkg::TIMER_W-1:0]      cfg_data,
	output logic [srsf_pkg::FI_W-1:0]         first_interval,
	output logic [srsf_pkg::CNT_W-1:0]        step_count,
	output logic signed [srsf_pkg::SLOPE_W-1:0] interval_slope,
	output logic [srsf_pkg::FIELD_W-1:0]      next_index
);
	import srsf_pkg::*;

	localparam int DVD_W     = SN_W + ADD_SHIFT + 1;
	localparam int DCW       = $clog2(DVD_W+1);
	localparam int FRAC_BITS = 56;
	localparam int IVD_BITS  = 51;
	localparam int SQ_W      = 2*FIELD_W;
	localparam int LIN_W     = 62;
	localparam int NUM_W     = 62;
	localparam int SAT_BIT   = 35;
	localparam int MAG_W     = SAT_BIT + 1;

	// config registers
	logic [TIMER_W-1:0] timer_q;
	logic [TOL_W-1:0]   tol_q;

	// segment registers
	logic [FIELD_W-1:0] from_q, to_q, total_q, idx_q;
	logic [FIELD_W:0]   j_q;
	logic [SQ_W-1:0]    f2_q, dmag_q, v2_q;
	logic               up_q, v2_small_q;
	logic [55:0]        prod_q;
	logic [IV_W-1:0]    first_q, last_q, iv_q, alw_q;
	logic signed [IV_W:0]      add_q;
	logic signed [LIN_W-1:0]   lin_q;
	logic signed [NUM_W-1:0]   num_q;
	logic signed [LIN_W:0]     diff_q;
	logic signed [LIN_W-1:0]   prodk_q;
	logic [2*CNT_W-1:0] kk_q;
	logic [63:0]        lhs_q;
	logic [IV_W+CNT_W-1:0] lim_q;
	logic [CNT_W-1:0]   k_q;
	logic               neg_q;

	// unit wiring
	logic               div_start, div_busy, div_ovf;
	logic [DVD_W-1:0]   div_dvd;
	logic [DSR_W-1:0]   div_dsr;
	logic [DCW-1:0]     div_nbits;
	logic [QUO_W-1:0]   quo;
	logic               sqrt_start, sqrt_busy;
	logic [ROOT_W-1:0]  root;
	logic [ROOT_W-1:0]  vq8;

	// combinational helpers
	logic [IV_W-1:0]        iv_new;
	logic signed [IV_W:0]   add_new;
	logic signed [IV_W:0]   dfl;
	logic signed [LIN_W-1:0] pk;
	logic signed [63:0]     lsum;
	logic [63:0]            labs;
	logic [LIN_W:0]         dabs;
	logic [79:0]            hsum;
	logic                   fallback;
	logic [SN_W-1:0]        add_mag, num_mag2;
	logic                   sat;
	logic [MAG_W-1:0]       mag, lim, magc;
	logic [IV_W:0]          rnd;

	assign iv_new  = quo[IV_W-1:0];
	assign add_new = signed'({1'b0, iv_new}) - signed'({1'b0, first_q});
	assign dfl     = signed'({1'b0, first_q}) - signed'({1'b0, last_q});
	assign pk      = LIN_W'(signed'({1'b0, k_q}) * dfl);
	assign lsum    = 64'(prodk_q) + 64'(signed'({num_q, 1'b0}));
	assign labs    = lsum[63] ? 64'(-lsum) : 64'(lsum);
	assign dabs    = diff_q[LIN_W] ? (LIN_W+1)'(-diff_q) : (LIN_W+1)'(diff_q);
	assign hsum    = {56'(dmag_q[SQ_W-1:FIELD_W]) * 56'(quo[31:0]), 24'b0} + 80'(prod_q);
	assign fallback = lhs_q > 64'(lim_q);
	assign add_mag  = add_q[IV_W] ? SN_W'(-add_q) : SN_W'(add_q);
	assign num_mag2 = num_q[NUM_W-1] ? SN_W'({-num_q, 1'b0}) : SN_W'({num_q, 1'b0});
	assign vq8      = v2_small_q ? ROOT_W'(256) : root;
	assign rnd      = {1'b0, first_q} + (IV_W+1)'(32768);

	// slope rounding and saturation
	assign sat  = div_ovf | (|quo[QUO_W-1:SAT_BIT]);
	assign mag  = ({1'b0, quo[SAT_BIT-1:0]} + MAG_W'(1)) >> 1;
	assign lim  = neg_q ? MAG_W'(33'h080000000) : MAG_W'(33'h07FFFFFFF);
	assign magc = (sat || mag > lim) ? lim : mag;

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		div_nbits = '0;
		case (op)
			OP_FRAC_GO: begin
				div_start = 1'b1;
				div_dvd   = {j_q[FIELD_W-1:0], 1'b1, 31'b0, {(DVD_W-FRAC_BITS){1'b0}}};
				div_dsr   = DSR_W'(total_q);
				div_nbits = DCW'(FRAC_BITS);
			end
			OP_IV_GO: begin
				div_start = 1'b1;
				div_dvd   = {timer_q, 24'b0, {(DVD_W-IVD_BITS){1'b0}}};
				div_dsr   = DSR_W'(vq8);
				div_nbits = DCW'(IVD_BITS);
			end
			OP_SLOPE_GO: begin
				div_start = 1'b1;
				div_dvd   = {(fallback ? add_mag : num_mag2), {(ADD_SHIFT+1){1'b0}}};
				div_dsr   = fallback ? DSR_W'(65536) : {kk_q, 16'b0};
				div_nbits = DCW'(DVD_W);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign sqrt_start = (op == OP_SQRT_GO);

	srsf_div #(.DVD_W(DVD_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dsr), .nbits(div_nbits), .busy(div_busy), .quo(quo), .ovf(div_ovf)
	);

	srsf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand({v2_q, 8'b0}),
		.busy(sqrt_busy), .root(root)
	);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= TIMER_RST;
			tol_q   <= TOL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_TIMER: timer_q <= cfg_data;
				REG_TOL:   tol_q   <= cfg_data[TOL_W-1:0];
				default:   timer_q <= timer_q;
			endcase
		end
	end

	// operation execution
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				from_q  <= start_speed;
				to_q    <= end_speed;
				total_q <= step_total;
				idx_q   <= step_index;
				j_q     <= {1'b0, step_index};
			end
			OP_SQUARE: begin
				f2_q   <= from_q * from_q;
				dmag_q <= to_q * to_q;
			end
			OP_DIFF: begin
				up_q   <= dmag_q >= f2_q;
				dmag_q <= (dmag_q >= f2_q) ? (dmag_q - f2_q) : (f2_q - dmag_q);
			end
			OP_MUL_LO: prod_q <= dmag_q[FIELD_W-1:0] * quo[31:0];
			OP_MUL_HI: prod_q <= 56'(hsum[79:32]);
			OP_V2: begin
				v2_q       <= up_q ? (f2_q + prod_q[SQ_W-1:0]) : (f2_q - prod_q[SQ_W-1:0]);
				v2_small_q <= (up_q ? (f2_q + prod_q[SQ_W-1:0])
					: (f2_q - prod_q[SQ_W-1:0])) <= SQ_W'(256);
			end
			OP_TAKE_FIRST: begin
				first_q <= iv_new;
				j_q     <= {1'b0, idx_q} + (FIELD_W+1)'(1);
			end
			OP_TAKE_SECOND: begin
				add_q  <= add_new;
				lin_q  <= LIN_W'(signed'({1'b0, iv_new})) + LIN_W'(add_new);
				num_q  <= NUM_W'(add_new);
				last_q <= iv_new;
				k_q    <= CNT_W'(2);
				j_q    <= {1'b0, idx_q} + (FIELD_W+1)'(2);
			end
			OP_RUN_ALW: begin
				iv_q   <= iv_new;
				alw_q  <= allowance(iv_new, tol_q);
				diff_q <= (LIN_W+1)'(lin_q) - (LIN_W+1)'(signed'({1'b0, iv_new}));
			end
			OP_RUN_ACC: begin
				num_q  <= num_q + NUM_W'(signed'({1'b0, iv_q}) - signed'({1'b0, first_q}));
				last_q <= iv_q;
				k_q    <= k_q + CNT_W'(1);
				lin_q  <= lin_q + LIN_W'(add_q);
				j_q    <= j_q + (FIELD_W+1)'(1);
			end
			OP_FIN1: begin
				prodk_q <= pk;
				alw_q   <= allowance(last_q, tol_q);
				kk_q    <= k_q * (k_q - CNT_W'(1));
			end
			OP_FIN2: begin
				lhs_q <= labs;
				lim_q <= alw_q * k_q;
			end
			OP_SLOPE_GO: neg_q <= fallback ? add_q[IV_W] : num_q[NUM_W-1];
			OP_RES_RUN: begin
				first_interval <= rnd[IV_W-1:16];
				step_count     <= k_q;
				interval_slope <= neg_q ? -magc[SLOPE_W-1:0] : magc[SLOPE_W-1:0];
				next_index     <= j_q[FIELD_W-1:0];
			end
			OP_RES_ONE: begin
				first_interval <= rnd[IV_W-1:16];
				step_count     <= CNT_W'(1);
				interval_slope <= '0;
				next_index     <= idx_q + FIELD_W'(1);
			end
			OP_RES_ZERO: begin
				first_interval <= '0;
				step_count     <= '0;
				interval_slope <= '0;
				next_index     <= idx_q;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	// status word
	assign status.finished  = idx_q >= total_q;
	assign status.last_step = ({1'b0, idx_q} + (FIELD_W+1)'(1)) >= {1'b0, total_q};
	assign status.run_more  = (j_q < {1'b0, total_q}) && (k_q < CNT_W'(MAX_RUN));
	assign status.dev_fail  = dabs > (LIN_W+1)'(alw_q);
	assign status.div_busy  = div_busy;
	assign status.sqrt_busy = sqrt_busy;
endmodule

FILE: src/srsf_ctrl.sv
// srsf_ctrl: segment fit sequencer, issues at most one datapath operation per cycle
// depends on srsf_pkg
module srsf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  srsf_pkg::dp_status_t  status,
	output srsf_pkg::dp_op_t      op,
	output logic                  busy,
	output logic                  done
);
	import srsf_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_SQUARE, S_CHECK, S_FRAC_GO, S_FRAC_WAIT, S_MUL_LO, S_MUL_HI, S_V2,
		S_SQRT_GO, S_SQRT_WAIT, S_IV_GO, S_IV_WAIT, S_TAKE, S_RUN_TEST, S_RUN_CHK,
		S_FIN1, S_FIN2, S_SLOPE_GO, S_SLOPE_WAIT, S_RES_RUN, S_RES_ONE, S_RES_ZERO
	} state_t;

	typedef enum logic [1:0] {
		PH_FIRST, PH_SECOND, PH_RUN
	} phase_t;

	state_t state_q, state_d;
	phase_t ph_q, ph_d;
	logic   busy_q, done_q;

	// next state and operation
	always_comb begin
		op      = OP_NOP;
		state_d = state_q;
		ph_d    = ph_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = OP_LOAD;
					state_d = S_SQUARE;
				end
			end
			S_SQUARE: begin
				op      = OP_SQUARE;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				op = OP_DIFF;
				if (status.finished) begin
					state_d = S_RES_ZERO;
				end else begin
					ph_d    = PH_FIRST;
					state_d = S_FRAC_GO;
				end
			end
			S_FRAC_GO: begin
				op      = OP_FRAC_GO;
				state_d = S_FRAC_WAIT;
			end
			S_FRAC_WAIT: if (!status.div_busy) state_d = S_MUL_LO;
			S_MUL_LO: begin
				op      = OP_MUL_LO;
				state_d = S_MUL_HI;
			end
			S_MUL_HI: begin
				op      = OP_MUL_HI;
				state_d = S_V2;
			end
			S_V2: begin
				op      = OP_V2;
				state_d = S_SQRT_GO;
			end
			S_SQRT_GO: begin
				op      = OP_SQRT_GO;
				state_d = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: if (!status.sqrt_busy) state_d = S_IV_GO;
			S_IV_GO: begin
				op      = OP_IV_GO;
				state_d = S_IV_WAIT;
			end
			S_IV_WAIT: if (!status.div_busy) state_d = S_TAKE;
			S_TAKE: begin
				case (ph_q)
					PH_FIRST: begin
						op = OP_TAKE_FIRST;
						if (status.last_step) begin
							state_d = S_RES_ONE;
						end else begin
							ph_d    = PH_SECOND;
							state_d = S_FRAC_GO;
						end
					end
					PH_SECOND: begin
						op      = OP_TAKE_SECOND;
						state_d = S_RUN_TEST;
					end
					default: begin
						op      = OP_RUN_ALW;
						state_d = S_RUN_CHK;
					end
				endcase
			end
			S_RUN_TEST: begin
				if (status.run_more) begin
					ph_d    = PH_RUN;
					state_d = S_FRAC_GO;
				end else begin
					state_d = S_FIN1;
				end
			end
			S_RUN_CHK: begin
				if (status.dev_fail) begin
					state_d = S_FIN1;
				end else begin
					op      = OP_RUN_ACC;
					state_d = S_RUN_TEST;
				end
			end
			S_FIN1: begin
				op      = OP_FIN1;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				op      = OP_FIN2;
				state_d = S_SLOPE_GO;
			end
			S_SLOPE_GO: begin
				op      = OP_SLOPE_GO;
				state_d = S_SLOPE_WAIT;
			end
			S_SLOPE_WAIT: if (!status.div_busy) state_d = S_RES_RUN;
			S_RES_RUN: begin
				op      = OP_RES_RUN;
				state_d = S_IDLE;
			end
			S_RES_ONE: begin
				op      = OP_RES_ONE;
				state_d = S_IDLE;
			end
			S_RES_ZERO: begin
				op      = OP_RES_ZERO;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_FIRST;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_q == S_RES_RUN) || (state_q == S_RES_ONE)
				|| (state_q == S_RES_ZERO);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule

FILE: src/stepper_ramp_segment_fitter.sv
// stepper_ramp_segment_fitter: top level, joins the sequencer and the datapath
// depends on srsf_pkg, srsf_ctrl, srsf_datapath
//
// One segment request is taken when start is high while busy is low; busy then stays
// high until the result. The result words hold on the outputs and done pulses for one
// cycle when they are new; nothing can hold the result off, so it must be taken in
// that cycle. Every step interval looked at costs a divider pass for the ramp fraction,
// a square root, a divider pass for the interval and the multiply and compare steps,
// and a segment of k steps looks at up to k+1 intervals, then, when k is two or more,
// runs one slope division. A finished ramp answers without a divider pass. The shared
// divider sets the pace.
module stepper_ramp_segment_fitter #(
	parameter int ADD_SHIFT = srsf_pkg::ADD_SHIFT_DEF,
	parameter int MAX_RUN   = srsf_pkg::MAX_RUN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [srsf_pkg::FIELD_W-1:0]        start_speed,
	input  logic [srsf_pkg::FIELD_W-1:0]        end_speed,
	input  logic [srsf_pkg::FIELD_W-1:0]        step_total,
	input  logic [srsf_pkg::FIELD_W-1:0]        step_index,
	input  logic                                cfg_wr_en,
	input  logic [0:0]                          cfg_index,
	input  logic [srsf_pkg::TIMER_W-1:0]        cfg_data,
	output logic                                done,
	output logic [srsf_pkg::FI_W-1:0]           first_interval,
	output logic [srsf_pkg::CNT_W-1:0]          step_count,
	output logic signed [srsf_pkg::SLOPE_W-1:0] interval_slope,
	output logic [srsf_pkg::FIELD_W-1:0]        next_index
);
	import srsf_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	// sequencer
	srsf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.op(op), .busy(busy), .done(done)
	);

	// arithmetic and result words
	srsf_datapath #(.ADD_SHIFT(ADD_SHIFT), .MAX_RUN(MAX_RUN)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .status(status),
		.start_speed(start_speed), .end_speed(end_speed),
		.step_total(step_total), .step_index(step_index),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.first_interval(first_interval), .step_count(step_count),
		.interval_slope(interval_slope), .next_index(next_index)
	);
endmodule
